// ===== hdl/rtte_pkg.sv =====
// Shared types, constants and the control program of the rtt estimator.
package rtte_pkg;

  // Input opcodes.
  localparam logic [1:0] OP_RTT     = 2'd0;
  localparam logic [1:0] OP_PAIR    = 2'd1;
  localparam logic [1:0] OP_BACKOFF = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ALPHA   = 3'd0;
  localparam logic [2:0] REG_BETA    = 3'd1;
  localparam logic [2:0] REG_KVAR    = 3'd2;
  localparam logic [2:0] REG_RTO_INI = 3'd3;
  localparam logic [2:0] REG_FLOOR   = 3'd4;
  localparam logic [2:0] REG_CEIL    = 3'd5;
  localparam logic [2:0] REG_BOFF    = 3'd6;

  // Register reset values.
  localparam logic [7:0]  ALPHA_RST   = 8'd32;
  localparam logic [7:0]  BETA_RST    = 8'd64;
  localparam logic [3:0]  KVAR_RST    = 4'd4;
  localparam logic [31:0] RTO_INI_RST = 32'd1000000;
  localparam logic [31:0] FLOOR_RST   = 32'd1000000;
  localparam logic [31:0] CEIL_RST    = 32'd60000000;
  localparam logic [3:0]  BOFF_RST    = 4'd2;

  // Kind of work held for the sequencer after an item is taken.
  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_BACKOFF,
    KIND_NOP,
    KIND_REJECT
  } kind_e;

  // Multiplier operand selects.
  typedef enum logic [2:0] {
    A_NBETA,
    A_BETA,
    A_NALPHA,
    A_ALPHA,
    A_KMUL,
    A_BOFF
  } asel_e;

  typedef enum logic [2:0] {
    B_RTTVAR,
    B_DELTA,
    B_SRTT,
    B_RSAMP,
    B_RTO
  } bsel_e;

  // Accumulator operation.
  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ADD
  } mac_e;

  // State register written by a step.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_RTTVAR,
    WR_SRTT,
    WR_RTO_EST,
    WR_RTO_BK
  } wr_e;

  typedef logic [3:0] pc_t;

  // One control word of the program.
  typedef struct packed {
    asel_e a;
    bsel_e b;
    mac_e  mac;
    wr_e   wr;
    logic  disp;
    logic  jump;
    pc_t   target;
    logic  fin;
  } ctrl_t;

  // Program step addresses.
  localparam pc_t PC_DISP = 4'd0;
  localparam pc_t PC_VMUL = 4'd1;
  localparam pc_t PC_WRV  = 4'd2;
  localparam pc_t PC_SMUL = 4'd3;
  localparam pc_t PC_WRS  = 4'd4;
  localparam pc_t PC_KVAR = 4'd5;
  localparam pc_t PC_RTO  = 4'd6;
  localparam pc_t PC_BK   = 4'd7;
  localparam pc_t PC_BKW  = 4'd8;

  // Control program ROM.
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t c;
    c = '{a: A_NBETA, b: B_RTTVAR, mac: MAC_HOLD, wr: WR_NONE,
          disp: 1'b0, jump: 1'b0, target: PC_DISP, fin: 1'b0};
    case (pc)
      PC_DISP: begin
        // Start the rttvar blend and branch on the kind of item.
        c.mac  = MAC_LOAD;
        c.a    = A_NBETA;
        c.b    = B_RTTVAR;
        c.disp = 1'b1;
      end
      PC_VMUL: begin
        c.mac = MAC_ADD;
        c.a   = A_BETA;
        c.b   = B_DELTA;
      end
      PC_WRV: begin
        c.wr  = WR_RTTVAR;
        c.mac = MAC_LOAD;
        c.a   = A_NALPHA;
        c.b   = B_SRTT;
      end
      PC_SMUL: begin
        c.mac = MAC_ADD;
        c.a   = A_ALPHA;
        c.b   = B_RSAMP;
      end
      PC_WRS: begin
        c.wr     = WR_SRTT;
        c.mac    = MAC_LOAD;
        c.a      = A_KMUL;
        c.b      = B_RTTVAR;
        c.jump   = 1'b1;
        c.target = PC_RTO;
      end
      PC_KVAR: begin
        c.mac = MAC_LOAD;
        c.a   = A_KMUL;
        c.b   = B_RTTVAR;
      end
      PC_RTO: begin
        c.wr  = WR_RTO_EST;
        c.fin = 1'b1;
      end
      PC_BK: begin
        c.mac = MAC_LOAD;
        c.a   = A_BOFF;
        c.b   = B_RTO;
      end
      PC_BKW: begin
        c.wr  = WR_RTO_BK;
        c.fin = 1'b1;
      end
      default: begin
        c.fin = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/rtte_seq.sv =====
// Step counter and program sequencer of the rtt estimator.
module rtte_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  adv_i,
  input  rtte_pkg::kind_e       kind_i,
  input  logic                  have_i,
  output logic                  busy_o,
  output logic                  fin_o,
  output rtte_pkg::ctrl_t       ctrl_o
);

  logic           busy_q;
  rtte_pkg::pc_t  pc_q, pc_d;
  rtte_pkg::ctrl_t cw;
  logic           no_work;

  // Fetch the control word and pick the next step.
  always_comb begin
    cw      = rtte_pkg::ucode(pc_q);
    no_work = (kind_i == rtte_pkg::KIND_NOP) || (kind_i == rtte_pkg::KIND_REJECT);
    pc_d    = pc_q + rtte_pkg::pc_t'(1);
    if (cw.disp) begin
      if (kind_i == rtte_pkg::KIND_BACKOFF) begin
        pc_d = rtte_pkg::PC_BK;
      end else if (!have_i) begin
        pc_d = rtte_pkg::PC_KVAR;
      end
    end else if (cw.jump) begin
      pc_d = cw.target;
    end
  end

  assign fin_o  = busy_q && (cw.fin || (cw.disp && no_work));
  assign busy_o = busy_q;
  assign ctrl_o = cw;

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= rtte_pkg::PC_DISP;
    end else if (start_i) begin
      busy_q <= 1'b1;
      pc_q   <= rtte_pkg::PC_DISP;
    end else if (busy_q && adv_i) begin
      if (fin_o) begin
        busy_q <= 1'b0;
      end else begin
        pc_q <= pc_d;
      end
    end
  end

endmodule

// ===== hdl/rtt_estimator_rto.sv =====
// Top level of the rtt estimator: registers, datapath and output word.
//
// Round-trip-time estimator with retransmission timeout.
// Input channel (in_valid_i/in_ready_o) takes one word: an rtt sample, a
// send/echo timestamp pair, or a timeout backoff. Output channel
// (out_valid_o/out_ready_i) returns exactly one word per input word with
// the status and the estimator state after that word.
// A control program in a small ROM runs the work on one shared 9 x 40-bit
// multiply-accumulate unit, one step per cycle unless the output stalls, one
// word at a time. After the accept cycle a later sample runs dispatch, rttvar
// product, rttvar write, srtt product, srtt write and timeout; a first sample
// dispatch, K * rttvar and timeout; a backoff dispatch, backoff product and
// backoff write; a rejected pair or an unused opcode dispatch alone.
// The output word is registered at the last step and held while the next
// input word is taken; if the receiver stalls, the next word waits at its
// last step until the output register frees. Reset clears the estimator
// state, loads the register defaults and sets the timeout to its initial
// value. Configuration is to be written through the APB port while no word
// is in flight, which the block does not enforce; pready is always high.
module rtt_estimator_rto #(
  parameter int FRACTION_BITS  = 8,
  parameter int GRANULARITY_US = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] rtt_us_i,
  input  logic [63:0] send_us_i,
  input  logic [63:0] echo_us_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [31:0] rto_us_o,
  output logic [31:0] srtt_us_o,
  output logic [31:0] rttvar_us_o,
  output logic [31:0] last_rtt_us_o,
  output logic [31:0] min_rtt_us_o,
  output logic [31:0] max_rtt_us_o,
  output logic [31:0] samples_seen_o
);

  localparam int SW = 32 + FRACTION_BITS;   // smoothed value width
  localparam int AW = SW + 9;               // accumulator width
  localparam logic [AW-1:0] GRAN = AW'(GRANULARITY_US) << FRACTION_BITS;

  // Configuration registers.
  logic [7:0]  alpha_q, beta_q;
  logic [3:0]  kmul_q, boff_q;
  logic [31:0] rto_ini_q, floor_q, ceil_q;
  logic        cfg_wr;

  // Estimator state.
  logic [SW-1:0] srtt_q, srtt_d, rttvar_q, rttvar_d;
  logic [31:0]   rto_q, rto_d;
  logic          have_q, have_d;
  logic [31:0]   count_q, lowest_q, highest_q, latest_q;

  // Working registers.
  rtte_pkg::kind_e kind_q, kind_d;
  logic [31:0]     samp_q, samp_d;
  logic [SW-1:0]   delta_q, delta_d;
  logic [AW-1:0]   acc_q, acc_d;
  logic            out_valid_q;

  // Sequencer interface.
  logic            accept, busy, fin, en, act;
  rtte_pkg::ctrl_t cw;

  // Datapath signals.
  logic [8:0]    mul_a;
  logic [SW-1:0] mul_b, r_fix;
  logic [AW-1:0] prod, kmax;
  logic [AW:0]   est_sum, est, est_lo, est_hi;
  logic [31:0]   rto_est, rto_bk;
  logic [64:0]   pair_diff;
  logic          pair_bad;
  logic          take_sample;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !busy;
  assign en         = !(fin && out_valid_q && !out_ready_i);
  assign act        = busy && en;

  rtte_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .adv_i   (en),
    .kind_i  (kind_q),
    .have_i  (have_q),
    .busy_o  (busy),
    .fin_o   (fin),
    .ctrl_o  (cw)
  );

  // APB register file.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= rtte_pkg::ALPHA_RST;
      beta_q    <= rtte_pkg::BETA_RST;
      kmul_q    <= rtte_pkg::KVAR_RST;
      rto_ini_q <= rtte_pkg::RTO_INI_RST;
      floor_q   <= rtte_pkg::FLOOR_RST;
      ceil_q    <= rtte_pkg::CEIL_RST;
      boff_q    <= rtte_pkg::BOFF_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        rtte_pkg::REG_ALPHA:   alpha_q   <= pwdata[7:0];
        rtte_pkg::REG_BETA:    beta_q    <= pwdata[7:0];
        rtte_pkg::REG_KVAR:    kmul_q    <= pwdata[3:0];
        rtte_pkg::REG_RTO_INI: rto_ini_q <= pwdata;
        rtte_pkg::REG_FLOOR:   floor_q   <= pwdata;
        rtte_pkg::REG_CEIL:    ceil_q    <= pwdata;
        rtte_pkg::REG_BOFF:    boff_q    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[4:2])
      rtte_pkg::REG_ALPHA:   prdata = {24'd0, alpha_q};
      rtte_pkg::REG_BETA:    prdata = {24'd0, beta_q};
      rtte_pkg::REG_KVAR:    prdata = {28'd0, kmul_q};
      rtte_pkg::REG_RTO_INI: prdata = rto_ini_q;
      rtte_pkg::REG_FLOOR:   prdata = floor_q;
      rtte_pkg::REG_CEIL:    prdata = ceil_q;
      rtte_pkg::REG_BOFF:    prdata = {28'd0, boff_q};
      default:               prdata = 32'd0;
    endcase
  end

  // Decode the input word into a sample or a command.
  always_comb begin
    pair_diff = {1'b0, echo_us_i} - {1'b0, send_us_i};
    pair_bad  = (send_us_i == 64'd0) || (echo_us_i == 64'd0) || (send_us_i >= echo_us_i);
    samp_d    = rtt_us_i;
    kind_d    = rtte_pkg::KIND_NOP;
    case (opcode_i)
      rtte_pkg::OP_RTT: begin
        kind_d = rtte_pkg::KIND_SAMPLE;
      end
      rtte_pkg::OP_PAIR: begin
        kind_d = pair_bad ? rtte_pkg::KIND_REJECT : rtte_pkg::KIND_SAMPLE;
        samp_d = (pair_diff[63:32] != 32'd0) ? 32'hFFFF_FFFF : pair_diff[31:0];
      end
      rtte_pkg::OP_BACKOFF: begin
        kind_d = rtte_pkg::KIND_BACKOFF;
      end
      default: begin
        kind_d = rtte_pkg::KIND_NOP;
      end
    endcase
  end

  // Shared multiply-accumulate unit.
  always_comb begin
    r_fix = SW'(samp_q) << FRACTION_BITS;
    case (cw.a)
      rtte_pkg::A_NBETA:  mul_a = 9'd256 - {1'b0, beta_q};
      rtte_pkg::A_BETA:   mul_a = {1'b0, beta_q};
      rtte_pkg::A_NALPHA: mul_a = 9'd256 - {1'b0, alpha_q};
      rtte_pkg::A_ALPHA:  mul_a = {1'b0, alpha_q};
      rtte_pkg::A_KMUL:   mul_a = {5'd0, kmul_q};
      rtte_pkg::A_BOFF:   mul_a = {5'd0, boff_q};
      default:            mul_a = 9'd0;
    endcase
    case (cw.b)
      rtte_pkg::B_RTTVAR: mul_b = rttvar_q;
      rtte_pkg::B_DELTA:  mul_b = delta_q;
      rtte_pkg::B_SRTT:   mul_b = srtt_q;
      rtte_pkg::B_RSAMP:  mul_b = r_fix;
      rtte_pkg::B_RTO:    mul_b = SW'(rto_q);
      default:            mul_b = '0;
    endcase
    prod  = AW'(mul_a) * AW'(mul_b);
    acc_d = acc_q;
    if (act) begin
      case (cw.mac)
        rtte_pkg::MAC_LOAD: acc_d = prod;
        rtte_pkg::MAC_ADD:  acc_d = acc_q + prod;
        default:            acc_d = acc_q;
      endcase
    end
  end

  // Timeout from the accumulated K * rttvar, and the backoff product.
  always_comb begin
    kmax    = (acc_q < GRAN) ? GRAN : acc_q;
    est_sum = {1'b0, kmax} + (AW+1)'(srtt_q);
    est     = est_sum >> FRACTION_BITS;
    est_lo  = (est < (AW+1)'(floor_q)) ? (AW+1)'(floor_q) : est;
    est_hi  = (est_lo > (AW+1)'(ceil_q)) ? (AW+1)'(ceil_q) : est_lo;
    rto_est = est_hi[31:0];
    rto_bk  = (acc_q > AW'(ceil_q)) ? ceil_q : acc_q[31:0];
  end

  // Next state of the estimator.
  always_comb begin
    take_sample = act && cw.disp && (kind_q == rtte_pkg::KIND_SAMPLE);
    srtt_d      = srtt_q;
    rttvar_d    = rttvar_q;
    rto_d       = rto_q;
    have_d      = have_q;
    delta_d     = (srtt_q > r_fix) ? (srtt_q - r_fix) : (r_fix - srtt_q);
    if (take_sample && !have_q) begin
      srtt_d   = r_fix;
      rttvar_d = r_fix >> 1;
      have_d   = 1'b1;
    end
    if (act) begin
      case (cw.wr)
        rtte_pkg::WR_RTTVAR: rttvar_d = acc_q[SW+7:8];
        rtte_pkg::WR_SRTT:   srtt_d   = acc_q[SW+7:8];
        rtte_pkg::WR_RTO_EST: rto_d   = rto_est;
        rtte_pkg::WR_RTO_BK:  rto_d   = rto_bk;
        default: ;
      endcase
    end
  end

  // State and statistics registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srtt_q      <= '0;
      rttvar_q    <= '0;
      rto_q       <= rtte_pkg::RTO_INI_RST;
      have_q      <= 1'b0;
      count_q     <= 32'd0;
      lowest_q    <= 32'hFFFF_FFFF;
      highest_q   <= 32'd0;
      latest_q    <= 32'd0;
      kind_q      <= rtte_pkg::KIND_NOP;
      out_valid_q <= 1'b0;
    end else begin
      srtt_q   <= srtt_d;
      rttvar_q <= rttvar_d;
      rto_q    <= rto_d;
      have_q   <= have_d;
      if (accept) begin
        kind_q <= kind_d;
      end
      if (take_sample) begin
        latest_q <= samp_q;
        if (count_q != 32'hFFFF_FFFF) begin
          count_q <= count_q + 32'd1;
        end
        if (samp_q < lowest_q) begin
          lowest_q <= samp_q;
        end
        if (samp_q > highest_q) begin
          highest_q <= samp_q;
        end
      end
      if (act && fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and the output word.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (accept) begin
      samp_q <= samp_d;
    end
    if (act && cw.disp) begin
      delta_q <= delta_d;
    end
    if (act && fin) begin
      status_o       <= (kind_q == rtte_pkg::KIND_REJECT);
      rto_us_o       <= rto_d;
      srtt_us_o      <= srtt_q[SW-1:FRACTION_BITS];
      rttvar_us_o    <= rttvar_q[SW-1:FRACTION_BITS];
      last_rtt_us_o  <= latest_q;
      min_rtt_us_o   <= lowest_q;
      max_rtt_us_o   <= highest_q;
      samples_seen_o <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/rtte_chk.sv =====
// Port-level checker of the rtt estimator and its bind statement.
module rtte_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] rto_us_o,
  input logic [31:0] min_rtt_us_o,
  input logic [31:0] max_rtt_us_o,
  input logic [31:0] samples_seen_o
);

  // A stalled output word stays valid and keeps its timeout.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rto_us_o))
    else $error("output word changed while stalled");

  // One word at a time: the input closes after a word is taken.
  a_in_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  // Once samples exist, the minimum never exceeds the maximum.
  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (samples_seen_o != 32'd0) |-> min_rtt_us_o <= max_rtt_us_o)
    else $error("min rtt above max rtt");

  // Without samples, the statistics keep their empty values.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (samples_seen_o == 32'd0) |->
      (min_rtt_us_o == 32'hFFFF_FFFF) && (max_rtt_us_o == 32'd0))
    else $error("statistics changed without a sample");

endmodule

bind rtt_estimator_rto rtte_chk u_rtte_chk (.*);
